// ===== design/tbec_pkg.sv =====
// Package for the tree balanced edge cut unit: item types, codes and the control program.
`default_nettype none

package tbec_pkg;

  // Fixed field widths of the channel items.
  localparam int WEIGHT_W = 16;
  localparam int PAR_W    = 6;
  localparam int DIFF_W   = 22;
  localparam int COUNT_W  = 6;
  localparam int ERR_W    = 2;
  localparam int UPC_W    = 5;

  localparam logic [DIFF_W-1:0]  DIFF_MAX  = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE     = 2'd0,
    ERR_ORDER    = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_code_t;

  typedef enum logic {
    KIND_SUMMARY = 1'b0,
    KIND_EDGE    = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] node_weight;
    logic [PAR_W-1:0]    parent_index;
    logic                last_node;
  } node_item_t;

  typedef struct packed {
    item_kind_t          item_kind;
    logic [DIFF_W-1:0]   min_difference;
    logic [COUNT_W-1:0]  edge_count;
    logic [PAR_W-1:0]    cut_parent;
    logic [PAR_W-1:0]    cut_child;
    err_code_t           error_code;
    logic                last_result;
  } result_item_t;

  // Datapath operation selected by one control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_REV_INIT,
    OP_READ,
    OP_REV_FETCH,
    OP_REV_WRITE,
    OP_MIN_INIT,
    OP_DIFF,
    OP_MIN_UPDATE,
    OP_EMIT_SUMMARY,
    OP_EDGE_INIT,
    OP_IDX_INC,
    OP_EMIT_EDGE,
    OP_CLEAR,
    OP_EMIT_ERROR
  } op_t;

  // Condition that keeps the step counter on the current step.
  typedef enum logic {
    HOLD_NONE,
    HOLD_OUT
  } hold_t;

  // Condition for taking the jump target instead of the next step.
  typedef enum logic [3:0] {
    J_NEVER,
    J_ALWAYS,
    J_NOT_START,
    J_ERR,
    J_IDX_ZERO,
    J_IDX_END,
    J_NO_EDGES,
    J_DIFF_NE,
    J_NOT_FIN
  } jump_t;

  typedef struct packed {
    op_t              op;
    hold_t            hold;
    jump_t            jump;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Step addresses of the control program.
  localparam logic [UPC_W-1:0] ST_LOAD      = 5'd0;
  localparam logic [UPC_W-1:0] ST_CHECK     = 5'd1;
  localparam logic [UPC_W-1:0] ST_REV_TEST  = 5'd2;
  localparam logic [UPC_W-1:0] ST_REV_RD    = 5'd3;
  localparam logic [UPC_W-1:0] ST_REV_FETCH = 5'd4;
  localparam logic [UPC_W-1:0] ST_REV_WR    = 5'd5;
  localparam logic [UPC_W-1:0] ST_MIN_INIT  = 5'd6;
  localparam logic [UPC_W-1:0] ST_MIN_TEST  = 5'd7;
  localparam logic [UPC_W-1:0] ST_MIN_RD    = 5'd8;
  localparam logic [UPC_W-1:0] ST_MIN_DIFF  = 5'd9;
  localparam logic [UPC_W-1:0] ST_MIN_CMP   = 5'd10;
  localparam logic [UPC_W-1:0] ST_SUMMARY   = 5'd11;
  localparam logic [UPC_W-1:0] ST_EDGE_INIT = 5'd12;
  localparam logic [UPC_W-1:0] ST_EDGE_TEST = 5'd13;
  localparam logic [UPC_W-1:0] ST_EDGE_RD   = 5'd14;
  localparam logic [UPC_W-1:0] ST_EDGE_DIFF = 5'd15;
  localparam logic [UPC_W-1:0] ST_EDGE_CHK  = 5'd16;
  localparam logic [UPC_W-1:0] ST_EDGE_EMIT = 5'd17;
  localparam logic [UPC_W-1:0] ST_FINISH    = 5'd18;
  localparam logic [UPC_W-1:0] ST_ERROR     = 5'd19;

  function automatic ucode_t uword(input op_t op, input hold_t hold, input jump_t jump,
                                   input logic [UPC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.hold   = hold;
    w.jump   = jump;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
    ucode_t w;
    case (pc)
      // Take nodes until the last one arrives.
      ST_LOAD:      w = uword(OP_LOAD,         HOLD_NONE, J_NOT_START, ST_LOAD);
      ST_CHECK:     w = uword(OP_REV_INIT,     HOLD_NONE, J_ERR,       ST_ERROR);
      // Reverse pass: add each subtree sum into its parent.
      ST_REV_TEST:  w = uword(OP_NOP,          HOLD_NONE, J_IDX_ZERO,  ST_MIN_INIT);
      ST_REV_RD:    w = uword(OP_READ,         HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_REV_FETCH: w = uword(OP_REV_FETCH,    HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_REV_WR:    w = uword(OP_REV_WRITE,    HOLD_NONE, J_ALWAYS,    ST_REV_TEST);
      // Minimum pass: least difference and its multiplicity together.
      ST_MIN_INIT:  w = uword(OP_MIN_INIT,     HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_MIN_TEST:  w = uword(OP_NOP,          HOLD_NONE, J_IDX_END,   ST_SUMMARY);
      ST_MIN_RD:    w = uword(OP_READ,         HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_MIN_DIFF:  w = uword(OP_DIFF,         HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_MIN_CMP:   w = uword(OP_MIN_UPDATE,   HOLD_NONE, J_ALWAYS,    ST_MIN_TEST);
      ST_SUMMARY:   w = uword(OP_EMIT_SUMMARY, HOLD_OUT,  J_NO_EDGES,  ST_FINISH);
      // Emit pass: one item for each edge that reaches the minimum.
      ST_EDGE_INIT: w = uword(OP_EDGE_INIT,    HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_EDGE_TEST: w = uword(OP_NOP,          HOLD_NONE, J_IDX_END,   ST_FINISH);
      ST_EDGE_RD:   w = uword(OP_READ,         HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_EDGE_DIFF: w = uword(OP_DIFF,         HOLD_NONE, J_NEVER,     ST_LOAD);
      ST_EDGE_CHK:  w = uword(OP_IDX_INC,      HOLD_NONE, J_DIFF_NE,   ST_EDGE_TEST);
      ST_EDGE_EMIT: w = uword(OP_EMIT_EDGE,    HOLD_OUT,  J_NOT_FIN,   ST_EDGE_TEST);
      ST_FINISH:    w = uword(OP_CLEAR,        HOLD_NONE, J_ALWAYS,    ST_LOAD);
      ST_ERROR:     w = uword(OP_EMIT_ERROR,   HOLD_OUT,  J_ALWAYS,    ST_FINISH);
      default:      w = uword(OP_NOP,          HOLD_NONE, J_ALWAYS,    ST_LOAD);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== design/tbec_if.sv =====
// Valid/ready channel interfaces for tree nodes and cut results.
`default_nettype none

interface tbec_node_if;
  import tbec_pkg::*;

  logic       valid;
  logic       ready;
  node_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tbec_result_if;
  import tbec_pkg::*;

  logic         valid;
  logic         ready;
  result_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/tree_balanced_edge_cut_unit.sv =====
// Top level of the tree balanced edge cut unit: microcoded sequencer and its datapath.
//
//   Channel  Dir  Item                        Accepted when
//   node     in   weight, parent, last flag   node.valid && node.ready
//   result   out  summary or edge item        result.valid && result.ready
//
// The load step takes non-last nodes. The last node starts the program: a check step,
// which goes to an error item if a flag is set, then a reverse pass for the subtree
// sums, a minimum pass and an emit pass over the edges with an emit step for each
// result item, and a final clear. The node channel is ready only on the load step and
// never during reset. The result register holds an item until it is taken, and the
// program holds on an emit step while it is full. Reset is synchronous.
`default_nettype none

module tree_balanced_edge_cut_unit #(
  parameter int MAX_NODES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  wire              clk,
  input  wire              rst,
  tbec_node_if.sink        node,
  tbec_result_if.source    result
);
  import tbec_pkg::*;

  localparam int IDX_W  = $clog2(MAX_NODES);
  localparam int CNT_W  = $clog2(MAX_NODES + 1);
  localparam int EW     = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam int SUM_W  = EW + IDX_W;
  localparam int D_W    = SUM_W + 1;
  localparam int PC_W   = (CNT_W > PAR_W) ? CNT_W : PAR_W;
  localparam int DS_W   = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
  localparam int CS_W   = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

  // Sequencer.
  logic [UPC_W-1:0] pc, pc_next;
  ucode_t           uc;
  logic             hold_now, take, go, start;

  // Run state.
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] total;
  logic [1:0]       err_flags;

  // Datapath registers.
  logic [CNT_W-1:0]   idx;
  logic [SUM_W-1:0]   s_i;
  logic [IDX_W-1:0]   p_reg;
  logic [SUM_W-1:0]   diff;
  logic [SUM_W-1:0]   best;
  logic [IDX_W-1:0]   cnt;
  logic [COUNT_W-1:0] k;
  logic [IDX_W-1:0]   child;
  logic [PAR_W-1:0]   edge_par;

  // Memories.
  logic [SUM_W-1:0] sum_mem [MAX_NODES];
  logic [PAR_W-1:0] par_mem [MAX_NODES];
  logic [SUM_W-1:0] sum_q;
  logic [PAR_W-1:0] par_q;
  logic             rd_en, sum_we, par_we;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [SUM_W-1:0] sum_wdata;
  logic [PAR_W-1:0] par_wdata;

  // Combinational helpers.
  logic             out_valid, out_busy;
  result_item_t     out_data;
  logic [EW-1:0]    w_eff;
  logic [PAR_W-1:0] p_in;
  logic             room;
  logic [D_W-1:0]   dbl, tot_x;
  logic [SUM_W-1:0] diff_abs;
  logic [DIFF_W-1:0]  best_sat;
  logic [COUNT_W-1:0] cnt_sat, k_inc;
  logic               fin;

  assign start    = node.valid && node.ready && node.data.last_node;
  assign out_busy = out_valid && !result.ready;
  assign node.ready   = (uc.op == OP_LOAD) && !rst;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  assign w_eff = node.data.node_weight[EW-1:0];
  assign p_in  = (count == '0) ? '0 : node.data.parent_index;
  assign room  = (count < CNT_W'(MAX_NODES));

  // Absolute difference of the two parts is |2*sum - total|.
  assign dbl      = {sum_q, 1'b0};
  assign tot_x    = D_W'(total);
  assign diff_abs = (dbl >= tot_x) ? SUM_W'(dbl - tot_x) : SUM_W'(tot_x - dbl);

  assign best_sat = (DS_W'(best) > DS_W'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(best);
  assign cnt_sat  = (CS_W'(cnt) > CS_W'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt);
  assign k_inc    = k + COUNT_W'(1);
  assign fin      = (k_inc == cnt_sat);

  // Step counter: hold, jump or advance.
  always_comb begin
    uc       = ucode_rom(pc);
    hold_now = (uc.hold == HOLD_OUT) && out_busy;
    go       = !hold_now;
    case (uc.jump)
      J_NEVER:     take = 1'b0;
      J_ALWAYS:    take = 1'b1;
      J_NOT_START: take = !start;
      J_ERR:       take = (err_flags != 2'b00);
      J_IDX_ZERO:  take = (idx == '0);
      J_IDX_END:   take = (idx >= count);
      J_NO_EDGES:  take = (cnt == '0);
      J_DIFF_NE:   take = (diff != best);
      J_NOT_FIN:   take = !fin;
      default:     take = 1'b0;
    endcase
    if (hold_now) begin
      pc_next = pc;
    end else if (take) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // Memory port controls.
  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = idx[IDX_W-1:0];
    sum_we    = 1'b0;
    par_we    = 1'b0;
    wr_addr   = count[IDX_W-1:0];
    sum_wdata = SUM_W'(w_eff);
    par_wdata = p_in;
    case (uc.op)
      OP_LOAD: begin
        sum_we = node.valid && room;
        par_we = node.valid && room;
      end
      OP_READ: begin
        rd_en = 1'b1;
      end
      OP_REV_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = IDX_W'(par_q);
      end
      OP_REV_WRITE: begin
        sum_we    = 1'b1;
        wr_addr   = p_reg;
        sum_wdata = sum_q + s_i;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Subtree sum and parent stores.
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[wr_addr] <= sum_wdata;
    end
    if (par_we) begin
      par_mem[wr_addr] <= par_wdata;
    end
    if (rd_en) begin
      sum_q <= sum_mem[rd_addr];
      par_q <= par_mem[rd_addr];
    end
  end

  // Run state: node count, total weight and error flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      total     <= '0;
      err_flags <= 2'b00;
    end else if (uc.op == OP_LOAD && node.valid) begin
      if (room) begin
        count <= count + CNT_W'(1);
        total <= total + SUM_W'(w_eff);
        if (count != '0 && PC_W'(node.data.parent_index) >= PC_W'(count)) begin
          err_flags[0] <= 1'b1;
        end
      end else begin
        err_flags[1] <= 1'b1;
      end
    end else if (uc.op == OP_CLEAR) begin
      count     <= '0;
      total     <= '0;
      err_flags <= 2'b00;
    end
  end

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_REV_INIT: begin
        idx <= count - CNT_W'(1);
      end
      OP_REV_FETCH: begin
        s_i   <= sum_q;
        p_reg <= IDX_W'(par_q);
      end
      OP_REV_WRITE: begin
        idx <= idx - CNT_W'(1);
      end
      OP_MIN_INIT: begin
        idx  <= CNT_W'(1);
        best <= total;
        cnt  <= '0;
      end
      OP_DIFF: begin
        diff     <= diff_abs;
        child    <= idx[IDX_W-1:0];
        edge_par <= par_q;
      end
      OP_MIN_UPDATE: begin
        idx <= idx + CNT_W'(1);
        if (diff < best) begin
          best <= diff;
          cnt  <= IDX_W'(1);
        end else if (diff == best) begin
          cnt <= cnt + IDX_W'(1);
        end
      end
      OP_EDGE_INIT: begin
        idx <= CNT_W'(1);
        k   <= '0;
      end
      OP_IDX_INC: begin
        idx <= idx + CNT_W'(1);
      end
      OP_EMIT_EDGE: begin
        if (go) begin
          k <= k_inc;
        end
      end
      default: begin
        k <= k;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && (uc.op == OP_EMIT_SUMMARY || uc.op == OP_EMIT_EDGE ||
                        uc.op == OP_EMIT_ERROR)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      case (uc.op)
        OP_EMIT_SUMMARY: begin
          out_data.item_kind      <= KIND_SUMMARY;
          out_data.min_difference <= best_sat;
          out_data.edge_count     <= cnt_sat;
          out_data.cut_parent     <= '0;
          out_data.cut_child      <= '0;
          out_data.error_code     <= ERR_NONE;
          out_data.last_result    <= (cnt == '0);
        end
        OP_EMIT_EDGE: begin
          out_data.item_kind      <= KIND_EDGE;
          out_data.min_difference <= best_sat;
          out_data.edge_count     <= cnt_sat;
          out_data.cut_parent     <= edge_par;
          out_data.cut_child      <= PAR_W'(child);
          out_data.error_code     <= ERR_NONE;
          out_data.last_result    <= fin;
        end
        OP_EMIT_ERROR: begin
          out_data.item_kind      <= KIND_SUMMARY;
          out_data.min_difference <= '0;
          out_data.edge_count     <= '0;
          out_data.cut_parent     <= '0;
          out_data.cut_child      <= '0;
          out_data.error_code     <= err_flags[0] ? ERR_ORDER : ERR_OVERFLOW;
          out_data.last_result    <= 1'b1;
        end
        default: begin
          out_data <= out_data;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
